@@ src/vde_pkg.sv @@
// Shared types and constants for the vernier dual encoder angle block
package vde_pkg;

  localparam int CFG_AW = 3;
  localparam int CFG_DW = 16;

  typedef logic [CFG_AW-1:0] cfg_addr_t;

  localparam cfg_addr_t REG_TEETH_A   = 3'd0;
  localparam cfg_addr_t REG_TEETH_B   = 3'd1;
  localparam cfg_addr_t REG_GEAR      = 3'd2;
  localparam cfg_addr_t REG_ZERO_A    = 3'd3;
  localparam cfg_addr_t REG_TOLERANCE = 3'd4;

  localparam logic [7:0]  RST_TEETH_A   = 8'd1;
  localparam logic [6:0]  RST_TEETH_B   = 7'd2;
  localparam logic [15:0] RST_GEAR      = 16'd256;
  localparam logic [15:0] RST_ZERO_A    = 16'd0;
  localparam logic [15:0] RST_TOLERANCE = 16'd521;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_DIV_SRCH,
    ST_FINAL,
    ST_DIV_FIN,
    ST_PUBLISH
  } state_t;

  typedef struct packed {
    logic load_item;
    logic start_srch;
    logic start_fin;
    logic next_i;
    logic set_match;
    logic cap_flange;
    logic clr_flange;
    logic publish;
  } cmd_t;

  typedef struct packed {
    logic range_ok;
    logic div_busy;
    logic div_done;
    logic hit;
    logic gear_zero;
    logic out_free;
  } status_t;

endpackage

@@ src/vde_if.sv @@
// Channel interfaces: encoder pair input, angle result output, register writes
interface vde_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] angle_a;
  logic [15:0] angle_b;

  modport source (output valid, output angle_a, output angle_b, input ready);
  modport sink   (input valid, input angle_a, input angle_b, output ready);
endinterface

interface vde_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] shaft_angle;
  logic signed [5:0]  turn_count;
  logic               matched;

  modport source (output valid, output shaft_angle, output turn_count, output matched,
                  input ready);
  modport sink   (input valid, input shaft_angle, input turn_count, input matched,
                  output ready);
endinterface

interface vde_cfg_if import vde_pkg::*; ();
  logic      valid;
  logic      ready;
  cfg_addr_t addr;
  logic [CFG_DW-1:0] data;

  modport source (output valid, output addr, output data, input ready);
  modport sink   (input valid, input addr, input data, output ready);
endinterface

@@ src/vde_div.sv @@
// Restoring unsigned divider, one quotient bit per cycle
module vde_div #(
  parameter int DW = 30,
  parameter int VW = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output logic          busy,
  output logic          done,
  output logic [DW-1:0] quo,
  output logic [VW-1:0] rem
);

  localparam int CNTW = $clog2(DW + 1);

  logic [DW-1:0]   quo_r;
  logic [VW-1:0]   rem_r;
  logic [VW-1:0]   dsr_r;
  logic [CNTW-1:0] cnt_r;
  logic            busy_r;
  logic            done_r;
  logic [VW:0]     trial;
  logic            fits;

  assign trial = {rem_r, quo_r[DW-1]};
  assign fits  = trial >= {1'b0, dsr_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && (cnt_r == CNTW'(1));
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNTW'(DW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNTW'(1);
        if (cnt_r == CNTW'(1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dsr_r <= divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[DW-2:0], fits};
      rem_r <= fits ? VW'(trial - {1'b0, dsr_r}) : trial[VW-1:0];
    end
  end

  assign busy = busy_r;
  assign done = done_r;
  assign quo  = quo_r;
  assign rem  = rem_r;

endmodule

@@ src/vde_dp.sv @@
// Datapath: registers, turn search operands, match test and flange scaling
module vde_dp import vde_pkg::*; #(
  parameter int MAX_TEETH_B = 64,
  parameter int ANGLE_BITS  = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  cmd_t               cmd,
  output status_t            sts,
  input  logic               cfg_valid,
  input  cfg_addr_t          cfg_addr,
  input  logic [CFG_DW-1:0]  cfg_data,
  input  logic [15:0]        angle_a,
  input  logic [15:0]        angle_b,
  input  logic               out_ready,
  output logic               out_valid,
  output logic signed [15:0] shaft_angle,
  output logic signed [5:0]  turn_count,
  output logic               matched
);

  localparam int AB = ANGLE_BITS;
  localparam int DW = AB + 14;
  localparam int PW = AB + 17;
  localparam int CW = (AB > 16) ? AB : 16;
  localparam logic [8:0] MAXT = 9'(MAX_TEETH_B);

  // configuration
  logic [7:0]  teeth_a_r;
  logic [6:0]  teeth_b_r;
  logic [15:0] gear_r;
  logic [15:0] zero_a_r;
  logic [15:0] tol_r;

  // item and search state
  logic [AB-1:0]      a_r;
  logic [AB-1:0]      b_r;
  logic signed [7:0]  i_r;
  logic [5:0]         held_r;
  logic               match_r;
  logic               neg_r;
  logic [15:0]        flange_r;

  // result register
  logic               out_valid_r;
  logic [15:0]        out_flange_r;
  logic [5:0]         out_turns_r;
  logic               out_match_r;

  logic [6:0]         tb;
  logic signed [7:0]  lo;
  logic signed [PW-1:0] prod;
  logic [PW-1:0]      prod_abs;
  logic [AB-1:0]      offs;
  logic [DW-1:0]      fin_bits;
  logic [DW-1:0]      fin_mag;
  logic [DW-1:0]      div_dividend;
  logic [15:0]        div_divisor;
  logic               div_start;
  logic               div_busy;
  logic               div_done;
  logic [DW-1:0]      quo;
  logic [15:0]        rem;
  logic [AB-1:0]      pred;
  logic [AB:0]        diff;
  logic [AB-1:0]      diff_abs;
  logic [AB-1:0]      u;
  logic [AB+15:0]     scaled;

  assign tb = ({2'b00, teeth_b_r} > MAXT) ? MAXT[6:0] : teeth_b_r;

  always_comb begin
    if (tb >= 7'd2) begin
      lo = 8'sd0 - $signed({1'b0, 7'((tb - 7'd2) >> 1)});
    end else if (tb == 7'd1) begin
      lo = 8'sd0;
    end else begin
      lo = 8'sd1;
    end
  end

  // (a + i*turn) * teeth_a, then its magnitude for the divider
  assign prod     = $signed({i_r, a_r}) * $signed({1'b0, teeth_a_r});
  assign prod_abs = prod[PW-1] ? (~prod + PW'(1)) : prod;

  // held*turn + offset, shifted by eight for the Q8.8 ratio
  assign offs     = a_r - AB'(zero_a_r);
  assign fin_bits = {held_r, offs, 8'b0};
  assign fin_mag  = held_r[5] ? (~fin_bits + DW'(1)) : fin_bits;

  assign div_start    = cmd.start_srch | cmd.start_fin;
  assign div_dividend = cmd.start_fin ? fin_mag : prod_abs[DW-1:0];
  assign div_divisor  = cmd.start_fin ? gear_r : 16'(tb);

  vde_div #(
    .DW (DW),
    .VW (16)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .busy     (div_busy),
    .done     (div_done),
    .quo      (quo),
    .rem      (rem)
  );

  // floor of a negative quotient: -q when exact, otherwise -q-1
  assign pred     = neg_r ? (~quo[AB-1:0] + AB'(rem == 16'd0)) : quo[AB-1:0];
  assign diff     = {1'b0, pred} - {1'b0, b_r};
  assign diff_abs = diff[AB] ? AB'(~diff + (AB+1)'(1)) : diff[AB-1:0];

  // truncate toward zero, wrap to one turn, rescale to sixteen bits
  assign u      = neg_r ? (~quo[AB-1:0] + AB'(1)) : quo[AB-1:0];
  assign scaled = {u, 16'b0} >> AB;

  always_comb begin
    sts           = '0;
    sts.range_ok  = $signed({i_r, 1'b0}) < $signed({2'b00, tb});
    sts.div_busy  = div_busy;
    sts.div_done  = div_done;
    sts.hit       = CW'(diff_abs) < CW'(tol_r);
    sts.gear_zero = gear_r == 16'd0;
    sts.out_free  = !out_valid_r || out_ready;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      teeth_a_r <= RST_TEETH_A;
      teeth_b_r <= RST_TEETH_B;
      gear_r    <= RST_GEAR;
      zero_a_r  <= RST_ZERO_A;
      tol_r     <= RST_TOLERANCE;
    end else if (cfg_valid) begin
      unique case (cfg_addr)
        REG_TEETH_A:   teeth_a_r <= cfg_data[7:0];
        REG_TEETH_B:   teeth_b_r <= cfg_data[6:0];
        REG_GEAR:      gear_r    <= cfg_data;
        REG_ZERO_A:    zero_a_r  <= cfg_data;
        REG_TOLERANCE: tol_r     <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r      <= '0;
      match_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.load_item) begin
        match_r <= 1'b0;
      end else if (cmd.set_match) begin
        held_r  <= i_r[5:0];
        match_r <= 1'b1;
      end
      if (cmd.publish) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      a_r <= AB'(angle_a);
      b_r <= AB'(angle_b);
      i_r <= lo;
    end else if (cmd.next_i) begin
      i_r <= i_r + 8'sd1;
    end
    if (cmd.start_srch) begin
      neg_r <= prod[PW-1];
    end else if (cmd.start_fin) begin
      neg_r <= held_r[5];
    end
    if (cmd.clr_flange) begin
      flange_r <= '0;
    end else if (cmd.cap_flange) begin
      flange_r <= scaled[15:0];
    end
    if (cmd.publish) begin
      out_flange_r <= flange_r;
      out_turns_r  <= held_r;
      out_match_r  <= match_r;
    end
  end

  assign out_valid    = out_valid_r;
  assign shaft_angle  = $signed(out_flange_r);
  assign turn_count   = $signed(out_turns_r);
  assign matched      = out_match_r;

endmodule

@@ src/vde_ctrl.sv @@
// Controller: sequences the turn search, the final scaling and the hand-over
module vde_ctrl import vde_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  input  status_t sts,
  output cmd_t    cmd
);

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_SEARCH;
      end
      ST_SEARCH: begin
        state_nxt = sts.range_ok ? ST_DIV_SRCH : ST_FINAL;
      end
      ST_DIV_SRCH: begin
        if (sts.div_done) state_nxt = sts.hit ? ST_FINAL : ST_SEARCH;
      end
      ST_FINAL: begin
        state_nxt = sts.gear_zero ? ST_PUBLISH : ST_DIV_FIN;
      end
      ST_DIV_FIN: begin
        if (sts.div_done) state_nxt = ST_PUBLISH;
      end
      ST_PUBLISH: begin
        if (sts.out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        // hold off items while reset is applied
        in_ready      = rst_n;
        cmd.load_item = in_valid && rst_n;
      end
      ST_SEARCH: begin
        cmd.start_srch = sts.range_ok;
      end
      ST_DIV_SRCH: begin
        cmd.set_match = sts.div_done && sts.hit;
        cmd.next_i    = sts.div_done && !sts.hit;
      end
      ST_FINAL: begin
        cmd.clr_flange = sts.gear_zero;
        cmd.start_fin  = !sts.gear_zero;
      end
      ST_DIV_FIN: begin
        cmd.cap_flange = sts.div_done;
      end
      ST_PUBLISH: begin
        cmd.publish = sts.out_free;
      end
      default: ;
    endcase
  end

endmodule

@@ src/vernier_dual_encoder_angle_top.sv @@
// Top level of the vernier dual encoder absolute angle block
// Each item takes one serial divide per turn tried and one for the gear ratio, on a divider
// that yields one quotient bit per cycle; a zero gear ratio skips the ratio divide.
// One item at a time: the next is taken only in idle, after the result register is loaded.
// Reset (synchronous, active low) restores register defaults and clears the held turn count.
module vernier_dual_encoder_angle_top import vde_pkg::*; #(
  parameter int MAX_TEETH_B = 64,
  parameter int ANGLE_BITS  = 16
) (
  input logic       clk,
  input logic       rst_n,
  vde_in_if.sink    in_ch,
  vde_out_if.source out_ch,
  vde_cfg_if.sink   cfg_ch
);

  cmd_t    cmd;
  status_t sts;

  assign cfg_ch.ready = rst_n;

  vde_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  vde_dp #(
    .MAX_TEETH_B (MAX_TEETH_B),
    .ANGLE_BITS  (ANGLE_BITS)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .sts          (sts),
    .cfg_valid    (cfg_ch.valid),
    .cfg_addr     (cfg_ch.addr),
    .cfg_data     (cfg_ch.data),
    .angle_a      (in_ch.angle_a),
    .angle_b      (in_ch.angle_b),
    .out_ready    (out_ch.ready),
    .out_valid    (out_ch.valid),
    .shaft_angle  (out_ch.shaft_angle),
    .turn_count   (out_ch.turn_count),
    .matched      (out_ch.matched)
  );

  a_publish_shows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.publish |=> out_ch.valid)
    else $error("published result not presented");

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.start_srch || cmd.start_fin) |-> !sts.div_busy)
    else $error("divide started while divider busy");

  a_take_at_rest: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |-> (!sts.div_busy && !sts.div_done))
    else $error("item taken while a divide is in flight");

  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    sts.div_done |-> $past(sts.div_busy))
    else $error("divider done without a preceding busy phase");

endmodule
